/* rtl/hdp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hdp_pkg;

    // Channel payload widths
    localparam int CH_W    = 8;
    localparam int EPOCH_W = 39;

    // Limits of a valid result
    localparam logic signed [EPOCH_W-1:0] EPOCH_MIN = -39'sd62135596800;
    localparam logic signed [EPOCH_W-1:0] EPOCH_MAX = 39'sd253402300799;

    // Parsed fields of one date string, handed from the scanner to the epoch pipeline
    typedef struct packed {
        logic        bad;     // syntax error, early end or incomplete date
        logic [13:0] year;
        logic [3:0]  mon;     // January = 0
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } t_date_rec;

    // Days in each month of a common year
    function automatic logic [4:0] f_month_len(input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd1:                     len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(367 * m / 12) for the March-based month number m of each month
    function automatic logic [8:0] f_month_offset(input logic [3:0] mon);
        logic [8:0] ofs;
        case (mon)
            4'd0:    ofs = 9'd336;
            4'd1:    ofs = 9'd367;
            4'd2:    ofs = 9'd30;
            4'd3:    ofs = 9'd61;
            4'd4:    ofs = 9'd91;
            4'd5:    ofs = 9'd122;
            4'd6:    ofs = 9'd152;
            4'd7:    ofs = 9'd183;
            4'd8:    ofs = 9'd214;
            4'd9:    ofs = 9'd244;
            4'd10:   ofs = 9'd275;
            default: ofs = 9'd305;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

/* rtl/hdp_char_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface hdp_char_if;
    logic                    valid;
    logic                    ready;
    logic [hdp_pkg::CH_W-1:0] ch;
    logic                    last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

/* rtl/hdp_date_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface hdp_date_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic signed [hdp_pkg::EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, output ok, output epoch_seconds, input ready);
    modport sink   (input valid, input ok, input epoch_seconds, output ready);
endinterface

`default_nettype wire

/* rtl/hdp_scanner.sv */
`timescale 1ns / 1ps
`default_nettype none

module hdp_scanner (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  logic [hdp_pkg::CH_W-1:0] i_ch,
    input  logic                     i_last,
    output logic                     o_rec_valid,
    output hdp_pkg::t_date_rec       o_rec
);

    // Parse phases
    localparam logic [4:0] PH_WDAY   = 5'd0;
    localparam logic [4:0] PH_SKIP   = 5'd1;
    localparam logic [4:0] PH_DAY1   = 5'd2;
    localparam logic [4:0] PH_DAY2   = 5'd3;
    localparam logic [4:0] PH_DAYSEP = 5'd4;
    localparam logic [4:0] PH_MON1   = 5'd5;
    localparam logic [4:0] PH_MON2   = 5'd6;
    localparam logic [4:0] PH_MON3   = 5'd7;
    localparam logic [4:0] PH_MONSEP = 5'd8;
    localparam logic [4:0] PH_ISP    = 5'd9;
    localparam logic [4:0] PH_ID1    = 5'd10;
    localparam logic [4:0] PH_ID2    = 5'd11;
    localparam logic [4:0] PH_Y1     = 5'd12;
    localparam logic [4:0] PH_Y2     = 5'd13;
    localparam logic [4:0] PH_Y3     = 5'd14;
    localparam logic [4:0] PH_Y4     = 5'd15;
    localparam logic [4:0] PH_TSEP   = 5'd16;
    localparam logic [4:0] PH_H1     = 5'd17;
    localparam logic [4:0] PH_H2     = 5'd18;
    localparam logic [4:0] PH_C1     = 5'd19;
    localparam logic [4:0] PH_M1     = 5'd20;
    localparam logic [4:0] PH_M2     = 5'd21;
    localparam logic [4:0] PH_C2     = 5'd22;
    localparam logic [4:0] PH_S1     = 5'd23;
    localparam logic [4:0] PH_S2     = 5'd24;
    localparam logic [4:0] PH_YSEP   = 5'd25;
    localparam logic [4:0] PH_DONE   = 5'd26;

    // Date formats
    localparam logic [1:0] FMT_NONE   = 2'd0;
    localparam logic [1:0] FMT_RFC822 = 2'd1;
    localparam logic [1:0] FMT_RFC850 = 2'd2;
    localparam logic [1:0] FMT_ASC    = 2'd3;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UJ    = 8'h4A;
    localparam logic [7:0] CH_UM    = 8'h4D;
    localparam logic [7:0] CH_UN    = 8'h4E;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_US    = 8'h53;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LR    = 8'h72;

    localparam logic [13:0] YEAR_PIVOT = 14'd70;
    localparam logic [13:0] YEAR_20XX  = 14'd2000;
    localparam logic [13:0] YEAR_19XX  = 14'd1900;

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic [13:0] f_push(input logic [13:0] acc, input logic [7:0] c);
        return 14'(acc * 14'd10 + {10'b0, c[3:0]});
    endfunction

    logic [4:0]  r_phase, n_phase, c_phase;
    logic [1:0]  r_fmt, n_fmt, c_fmt;
    logic [15:0] r_mltr, n_mltr, c_mltr;
    logic [6:0]  r_day, n_day, c_day;
    logic [3:0]  r_mon, n_mon, c_mon;
    logic [13:0] r_year, n_year, c_year;
    logic [6:0]  r_hour, n_hour, c_hour;
    logic [6:0]  r_min, n_min, c_min;
    logic [6:0]  r_sec, n_sec, c_sec;
    logic        r_err, n_err, c_err;

    // Consume one character: advance the phase and fold it into the fields
    always_comb begin
        logic [4:0]  ph;
        logic        sp_eaten;
        logic        dig;
        logic [13:0] yr_t;
        c_phase = r_phase;
        c_fmt   = r_fmt;
        c_mltr  = r_mltr;
        c_day   = r_day;
        c_mon   = r_mon;
        c_year  = r_year;
        c_hour  = r_hour;
        c_min   = r_min;
        c_sec   = r_sec;
        c_err   = r_err;
        ph       = r_phase;
        sp_eaten = 1'b0;
        dig      = f_is_digit(i_ch);
        yr_t     = '0;
        if (i_take && (r_phase != PH_DONE) && !r_err) begin
            if (i_ch == CH_NUL) begin
                c_err = 1'b1;
            end else begin
                // leave the space run, and drop one optional space before an asctime day
                if ((ph == PH_SKIP) && (i_ch != CH_SP)) begin
                    ph = (r_fmt == FMT_ASC) ? PH_MON1 : PH_DAY1;
                end
                if (ph == PH_ISP) begin
                    ph       = PH_ID1;
                    sp_eaten = (i_ch == CH_SP);
                end
                c_phase = ph;
                if (!sp_eaten) begin
                    unique case (ph)
                        PH_WDAY: begin
                            if (i_ch == CH_COMMA) begin
                                c_phase = PH_SKIP;
                            end else if (i_ch == CH_SP) begin
                                c_fmt   = FMT_ASC;
                                c_phase = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                        end
                        PH_DAY1, PH_ID1: begin
                            c_day   = dig ? 7'(f_push(14'd0, i_ch)) : 7'd0;
                            c_err   = !dig;
                            c_phase = (ph == PH_DAY1) ? PH_DAY2 : PH_ID2;
                        end
                        PH_DAY2: begin
                            if (dig) c_day = 7'(f_push({7'b0, r_day}, i_ch));
                            c_err   = !dig;
                            c_phase = PH_DAYSEP;
                        end
                        PH_DAYSEP: begin
                            if (i_ch == CH_SP) c_fmt = FMT_RFC822;
                            else if (i_ch == CH_DASH) c_fmt = FMT_RFC850;
                            else c_err = 1'b1;
                            c_phase = PH_MON1;
                        end
                        PH_MON1: begin
                            case (i_ch) inside
                                CH_UJ, CH_UF, CH_UM, CH_UA, CH_US, CH_UO, CH_UN, CH_UD: begin
                                end
                                default: c_err = 1'b1;
                            endcase
                            c_mltr  = {8'h00, i_ch};
                            c_phase = PH_MON2;
                        end
                        PH_MON2: begin
                            c_mltr  = {i_ch, r_mltr[7:0]};
                            c_phase = PH_MON3;
                        end
                        PH_MON3: begin
                            case (r_mltr[7:0])
                                CH_UJ: c_mon = (r_mltr[15:8] == CH_LA) ? 4'd0 :
                                               (i_ch == CH_LN) ? 4'd5 : 4'd6;
                                CH_UF: c_mon = 4'd1;
                                CH_UM: c_mon = (i_ch == CH_LR) ? 4'd2 : 4'd4;
                                CH_UA: c_mon = (r_mltr[15:8] == CH_LP) ? 4'd3 : 4'd7;
                                CH_US: c_mon = 4'd8;
                                CH_UO: c_mon = 4'd9;
                                CH_UN: c_mon = 4'd10;
                                CH_UD: c_mon = 4'd11;
                                default: c_err = 1'b1;
                            endcase
                            c_phase = PH_MONSEP;
                        end
                        PH_MONSEP: begin
                            if (((r_fmt == FMT_RFC822) && (i_ch != CH_SP)) ||
                                ((r_fmt == FMT_RFC850) && (i_ch != CH_DASH))) begin
                                c_err = 1'b1;
                            end
                            c_phase = (r_fmt == FMT_ASC) ? PH_ISP : PH_Y1;
                        end
                        PH_ID2: begin
                            if (i_ch == CH_SP) begin
                                c_phase = PH_H1;
                            end else begin
                                if (dig) c_day = 7'(f_push({7'b0, r_day}, i_ch));
                                c_err   = !dig;
                                c_phase = PH_TSEP;
                            end
                        end
                        PH_Y1: begin
                            c_year  = dig ? f_push(14'd0, i_ch) : 14'd0;
                            c_err   = !dig;
                            c_phase = PH_Y2;
                        end
                        PH_Y2: begin
                            yr_t  = dig ? f_push(r_year, i_ch) : r_year;
                            c_err = !dig;
                            if (r_fmt == FMT_RFC850) begin
                                c_year  = yr_t + ((yr_t < YEAR_PIVOT) ? YEAR_20XX : YEAR_19XX);
                                c_phase = PH_TSEP;
                            end else begin
                                c_year  = yr_t;
                                c_phase = PH_Y3;
                            end
                        end
                        PH_Y3: begin
                            if (dig) c_year = f_push(r_year, i_ch);
                            c_err   = !dig;
                            c_phase = PH_Y4;
                        end
                        PH_Y4: begin
                            if (dig) c_year = f_push(r_year, i_ch);
                            c_err   = !dig;
                            c_phase = (r_fmt == FMT_ASC) ? PH_DONE : PH_TSEP;
                        end
                        PH_TSEP: begin
                            c_err   = (i_ch != CH_SP);
                            c_phase = PH_H1;
                        end
                        PH_H1: begin
                            c_hour  = dig ? 7'(f_push(14'd0, i_ch)) : 7'd0;
                            c_err   = !dig;
                            c_phase = PH_H2;
                        end
                        PH_H2: begin
                            if (dig) c_hour = 7'(f_push({7'b0, r_hour}, i_ch));
                            c_err   = !dig;
                            c_phase = PH_C1;
                        end
                        PH_C1: begin
                            c_err   = (i_ch != CH_COLON);
                            c_phase = PH_M1;
                        end
                        PH_M1: begin
                            c_min   = dig ? 7'(f_push(14'd0, i_ch)) : 7'd0;
                            c_err   = !dig;
                            c_phase = PH_M2;
                        end
                        PH_M2: begin
                            if (dig) c_min = 7'(f_push({7'b0, r_min}, i_ch));
                            c_err   = !dig;
                            c_phase = PH_C2;
                        end
                        PH_C2: begin
                            c_err   = (i_ch != CH_COLON);
                            c_phase = PH_S1;
                        end
                        PH_S1: begin
                            c_sec   = dig ? 7'(f_push(14'd0, i_ch)) : 7'd0;
                            c_err   = !dig;
                            c_phase = PH_S2;
                        end
                        PH_S2: begin
                            if (dig) c_sec = 7'(f_push({7'b0, r_sec}, i_ch));
                            c_err   = !dig;
                            c_phase = (r_fmt == FMT_ASC) ? PH_YSEP : PH_DONE;
                        end
                        PH_YSEP: begin
                            c_err   = (i_ch != CH_SP);
                            c_phase = PH_Y1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // Return to the start state after the last character
    always_comb begin
        if (i_take && i_last) begin
            n_phase = PH_WDAY;
            n_fmt   = FMT_NONE;
            n_mltr  = '0;
            n_day   = '0;
            n_mon   = '0;
            n_year  = '0;
            n_hour  = '0;
            n_min   = '0;
            n_sec   = '0;
            n_err   = 1'b0;
        end else begin
            n_phase = c_phase;
            n_fmt   = c_fmt;
            n_mltr  = c_mltr;
            n_day   = c_day;
            n_mon   = c_mon;
            n_year  = c_year;
            n_hour  = c_hour;
            n_min   = c_min;
            n_sec   = c_sec;
            n_err   = c_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WDAY;
            r_fmt   <= FMT_NONE;
            r_mltr  <= '0;
            r_day   <= '0;
            r_mon   <= '0;
            r_year  <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_fmt   <= n_fmt;
            r_mltr  <= n_mltr;
            r_day   <= n_day;
            r_mon   <= n_mon;
            r_year  <= n_year;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_err   <= n_err;
        end
    end

    // Hand the finished fields on with the last character
    assign o_rec_valid = i_take && i_last;
    assign o_rec = '{bad:    c_err || (c_phase != PH_DONE),
                     year:   c_year,
                     mon:    c_mon,
                     day:    c_day,
                     hour:   c_hour,
                     minute: c_min,
                     second: c_sec};

endmodule

`default_nettype wire

/* rtl/hdp_epoch_calc.sv */
`timescale 1ns / 1ps
`default_nettype none

module hdp_epoch_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rec_valid,
    input  hdp_pkg::t_date_rec i_rec,
    output logic               o_rec_ready,
    hdp_date_if.source         o_date
);

    localparam int STAGES = 6;

    // Reciprocal of 100 scaled by 2^19, exact for years up to 9999
    localparam logic [26:0] RECIP_100 = 27'd5243;
    localparam int          RECIP_SH  = 19;

    localparam logic [3:0]  MON_FEB    = 4'd1;
    localparam logic [3:0]  MON_MAR    = 4'd2;
    localparam logic [3:0]  MON_DEC    = 4'd11;
    localparam logic [6:0]  DAY_LEAP   = 7'd29;
    localparam logic [6:0]  HOUR_MAX   = 7'd23;
    localparam logic [6:0]  MINSEC_MAX = 7'd59;
    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    // -1 - 719527 + 31 + 28 - 30
    localparam logic [24:0] DAY_BIAS   = 25'd719499;

    logic [STAGES-1:0] r_vld, n_vld, w_ld;

    hdp_pkg::t_date_rec r_s1, n_s1;
    hdp_pkg::t_date_rec r_s2, n_s2;
    logic [7:0]         r_s2_q, n_s2_q;

    logic               r_s3_ok, n_s3_ok;
    logic [13:0]        r_s3_yadj, n_s3_yadj;
    logic [7:0]         r_s3_qa, n_s3_qa;
    logic [8:0]         r_s3_moff, n_s3_moff;
    logic [6:0]         r_s3_day, r_s3_hour, r_s3_min, r_s3_sec;

    logic               r_s4_ok;
    logic signed [24:0] r_s4_days, n_s4_days;
    logic [18:0]        r_s4_tod, n_s4_tod;

    logic               r_s5_ok;
    logic signed [39:0] r_s5_prod, n_s5_prod;
    logic [18:0]        r_s5_tod;

    logic                               r_o_ok;
    logic signed [hdp_pkg::EPOCH_W-1:0] r_o_epoch, n_o_epoch;

    logic [14:0] w_rem;
    logic        w_hund;
    logic        w_leap;
    logic        w_jan_feb;
    logic        w_day_ok;
    logic [24:0] w_pos, w_neg;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        w_ld[STAGES-1] = !r_vld[STAGES-1] || o_date.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
        n_vld[0] = w_ld[0] ? i_rec_valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = w_ld[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    assign o_rec_ready = w_ld[0];

    // Stage 1: hold the parsed fields
    assign n_s1 = i_rec;

    // Stage 2: year / 100 by reciprocal multiply
    assign n_s2     = r_s1;
    always_comb n_s2_q = 8'(27'(r_s1.year) * RECIP_100 >> RECIP_SH);

    // Stage 3: leap year, field checks, March-based year and month
    always_comb begin
        w_rem     = 15'(r_s2.year) - 15'(15'(r_s2_q) * 15'd100);
        w_hund    = (w_rem == 15'd0);
        w_leap    = (r_s2.year[1:0] == 2'b00) && !(w_hund && (r_s2_q[1:0] != 2'b00));
        w_jan_feb = (r_s2.mon < MON_MAR);
        if ((r_s2.day == DAY_LEAP) && (r_s2.mon == MON_FEB)) begin
            w_day_ok = w_leap;
        end else begin
            w_day_ok = (r_s2.day <= {2'b00, hdp_pkg::f_month_len(r_s2.mon)});
        end
        n_s3_ok   = !r_s2.bad && (r_s2.mon <= MON_DEC) &&
                    (r_s2.hour <= HOUR_MAX) && (r_s2.minute <= MINSEC_MAX) &&
                    (r_s2.second <= MINSEC_MAX) &&
                    (r_s2.year >= YEAR_MIN) && (r_s2.year <= YEAR_MAX) && w_day_ok;
        n_s3_yadj = r_s2.year - {13'b0, w_jan_feb};
        n_s3_qa   = r_s2_q - {7'b0, w_jan_feb && w_hund};
        n_s3_moff = hdp_pkg::f_month_offset(r_s2.mon);
    end

    // Stage 4: day count from the epoch and seconds into the day
    always_comb begin
        w_pos = 25'(r_s3_yadj) * 25'd365 + 25'(r_s3_yadj >> 2) + 25'(r_s3_qa >> 2) +
                25'(r_s3_moff) + 25'(r_s3_day);
        w_neg = 25'(r_s3_qa) + DAY_BIAS;
        n_s4_days = $signed(w_pos - w_neg);
        n_s4_tod  = 19'(r_s3_hour) * 19'd3600 + 19'(r_s3_min) * 19'd60 + 19'(r_s3_sec);
    end

    // Stage 5: days to seconds
    assign n_s5_prod = 40'(r_s4_days) * 40'sd86400;

    // Stage 6: add the time of day, zero a rejected date
    assign n_o_epoch = r_s5_ok ?
        hdp_pkg::EPOCH_W'(r_s5_prod + $signed({21'b0, r_s5_tod})) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_s1 <= n_s1;
        end
        if (w_ld[1]) begin
            r_s2   <= n_s2;
            r_s2_q <= n_s2_q;
        end
        if (w_ld[2]) begin
            r_s3_ok   <= n_s3_ok;
            r_s3_yadj <= n_s3_yadj;
            r_s3_qa   <= n_s3_qa;
            r_s3_moff <= n_s3_moff;
            r_s3_day  <= r_s2.day;
            r_s3_hour <= r_s2.hour;
            r_s3_min  <= r_s2.minute;
            r_s3_sec  <= r_s2.second;
        end
        if (w_ld[3]) begin
            r_s4_ok   <= r_s3_ok;
            r_s4_days <= n_s4_days;
            r_s4_tod  <= n_s4_tod;
        end
        if (w_ld[4]) begin
            r_s5_ok   <= r_s4_ok;
            r_s5_prod <= n_s5_prod;
            r_s5_tod  <= r_s4_tod;
        end
        if (w_ld[5]) begin
            r_o_ok    <= r_s5_ok;
            r_o_epoch <= n_o_epoch;
        end
    end

    assign o_date.valid         = r_vld[STAGES-1];
    assign o_date.ok            = r_o_ok;
    assign o_date.epoch_seconds = r_o_epoch;

endmodule

`default_nettype wire

/* rtl/http_date_parser_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                           Request
// i_char    in   ch[7:0], last                     one character of a date string
// o_date    out  ok, epoch_seconds[38:0] signed    one parsed date per string
//
// One character is taken every cycle while i_char.ready is high.
// After its last character, a result is registered through the six-stage
// epoch pipeline (year/100 multiply, checks, day sum, seconds multiply, add).
// Reset is synchronous and active low; it returns the parser to the weekday
// scan and empties the pipeline.
// A stalled o_date backs up stage by stage; i_char.ready drops only when all
// six stages hold results.

module http_date_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hdp_char_if.sink   i_char,
    hdp_date_if.source o_date
);

    logic               w_take;
    logic               w_rec_valid;
    logic               w_rec_ready;
    hdp_pkg::t_date_rec w_rec;

    // Accept a character whenever the pipeline can take a finished date
    assign i_char.ready = w_rec_ready;
    assign w_take       = i_char.valid && w_rec_ready;

    hdp_scanner u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_ch        (i_char.ch),
        .i_last      (i_char.last),
        .o_rec_valid (w_rec_valid),
        .o_rec       (w_rec)
    );

    hdp_epoch_calc u_epoch_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (w_rec_valid),
        .i_rec       (w_rec),
        .o_rec_ready (w_rec_ready),
        .o_date      (o_date)
    );

    // A rejected date carries zero seconds
    a_zero_when_bad : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_date.valid && !o_date.ok) |-> (o_date.epoch_seconds == '0))
        else $error("rejected date with nonzero seconds");

    // An accepted date lies in years 1..9999
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_date.valid && o_date.ok) |->
        ((o_date.epoch_seconds >= hdp_pkg::EPOCH_MIN) &&
         (o_date.epoch_seconds <= hdp_pkg::EPOCH_MAX)))
        else $error("epoch seconds out of range");

    // Input back-pressure only comes from a stalled output
    a_ready_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_char.ready |-> (o_date.valid && !o_date.ready))
        else $error("input stalled while output drains");

    // A stalled result holds its seconds
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_date.valid && !o_date.ready) |=> $stable(o_date.epoch_seconds))
        else $error("stalled result changed");

endmodule

`default_nettype wire
